// ===== hw/rtl/tdcewd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package tdcewd_pkg;

    localparam int unsigned WORD_W     = 32;
    localparam int unsigned CLASS_W    = 4;
    localparam int unsigned CHAN_W     = 5;
    localparam int unsigned SLOT_W     = 2;
    localparam int unsigned VALUE_W    = 27;
    localparam int unsigned GEO_W      = 5;
    localparam int unsigned ID_W       = 12;
    localparam int unsigned TYPE_W     = 5;
    localparam int unsigned HIT_CNT_W  = 2;
    localparam int unsigned TRIG_W     = 22;
    localparam int unsigned TIME_W     = 20;

    // word classes
    localparam logic [CLASS_W-1:0] CLS_HEADER     = 4'd0;
    localparam logic [CLASS_W-1:0] CLS_HIT_KEPT   = 4'd1;
    localparam logic [CLASS_W-1:0] CLS_HIT_DROP   = 4'd2;
    localparam logic [CLASS_W-1:0] CLS_TDC_HEADER = 4'd3;
    localparam logic [CLASS_W-1:0] CLS_TRAILER    = 4'd4;
    localparam logic [CLASS_W-1:0] CLS_TAG_LOW    = 4'd5;
    localparam logic [CLASS_W-1:0] CLS_TAG_HIGH   = 4'd6;
    localparam logic [CLASS_W-1:0] CLS_UNKNOWN    = 4'd7;
    localparam logic [CLASS_W-1:0] CLS_BAD_HEADER = 4'd8;
    localparam logic [CLASS_W-1:0] CLS_IGNORED    = 4'd9;

    // word types, bits 31..27
    localparam logic [TYPE_W-1:0] TYPE_EVENT_HEADER = 5'h08;
    localparam logic [TYPE_W-1:0] TYPE_MEASUREMENT  = 5'h00;
    localparam logic [TYPE_W-1:0] TYPE_TDC_HEADER   = 5'h01;
    localparam logic [TYPE_W-1:0] TYPE_TRAILER      = 5'h03;
    localparam logic [TYPE_W-1:0] TYPE_TAG_LOW      = 5'h10;
    localparam logic [TYPE_W-1:0] TYPE_TAG_HIGH     = 5'h11;

    localparam logic [SLOT_W-1:0] SLOT_DROPPED = 2'd3;

    typedef struct packed {
        logic [CLASS_W-1:0] word_class;
        logic [CHAN_W-1:0]  channel;
        logic               edge_res;
        logic [SLOT_W-1:0]  hit_slot;
        logic [VALUE_W-1:0] value;
        logic [GEO_W-1:0]   geo_address;
        logic [ID_W-1:0]    tdc_channel_id;
        logic [ID_W-1:0]    tdc_packet_id;
    } result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/tdcewd_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface tdcewd_in_if;
    import tdcewd_pkg::*;

    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] word;
    logic              first_of_event;
    logic              last_of_event;

    modport source (output valid, output word, output first_of_event,
                    output last_of_event, input ready);
    modport sink (input valid, input word, input first_of_event,
                  input last_of_event, output ready);
endinterface

interface tdcewd_out_if;
    import tdcewd_pkg::*;

    logic               valid;
    logic               ready;
    logic [CLASS_W-1:0] word_class;
    logic [CHAN_W-1:0]  channel;
    logic               edge_res;
    logic [SLOT_W-1:0]  hit_slot;
    logic [VALUE_W-1:0] value;
    logic [GEO_W-1:0]   geo_address;
    logic [ID_W-1:0]    tdc_channel_id;
    logic [ID_W-1:0]    tdc_packet_id;

    modport source (output valid, output word_class, output channel, output edge_res,
                    output hit_slot, output value, output geo_address,
                    output tdc_channel_id, output tdc_packet_id, input ready);
    modport sink (input valid, input word_class, input channel, input edge_res,
                  input hit_slot, input value, input geo_address,
                  input tdc_channel_id, input tdc_packet_id, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/tdc_event_word_decoder_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Decodes readout words of a multi-hit TDC event, one decoded word out for every word in.
// A word is taken every cycle while the output is not stalled; it goes through an input
// register and then a result register, from which its decoded word is presented. The
// per-channel hit counters are read from the word in the input register and updated as
// the result register loads, which is what lets consecutive hits on the same channel
// follow each other with no gap. The result register keeps accepting words while the
// downstream side is ready; when it stalls, one more word is held in the input register
// before raw.ready drops.
module tdc_event_word_decoder_core #(
    parameter int unsigned CHANNELS      = 16,
    parameter int unsigned HITS_PER_EDGE = 3
) (
    input  wire              clk,
    input  wire              rst_n,
    tdcewd_in_if.sink        raw,
    tdcewd_out_if.source     decoded
);
    import tdcewd_pkg::*;

    localparam int unsigned IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // input register
    logic              s1_valid_reg;
    logic [WORD_W-1:0] s1_word_reg;
    logic              s1_first_reg;
    logic              s1_last_reg;

    // result register
    logic              out_valid_reg;
    result_t           out_reg;
    result_t           out_next;

    // event state
    logic                 event_open_reg;
    logic                 event_open_next;
    logic [GEO_W-1:0]     geo_reg;
    logic [GEO_W-1:0]     geo_next;
    logic [HIT_CNT_W-1:0] lead_reg [CHANNELS];
    logic [HIT_CNT_W-1:0] trail_reg [CHANNELS];

    logic                 out_load;
    logic                 s1_load;
    logic [TYPE_W-1:0]    w_type;
    logic [CHAN_W-1:0]    w_chan;
    logic                 w_trailing;
    logic                 in_range;
    logic [IDX_W-1:0]     ch_idx;
    logic [HIT_CNT_W-1:0] cnt_cur;
    logic                 hit_keep;
    logic                 good_header;

    assign out_load = s1_valid_reg && (!out_valid_reg || decoded.ready);
    assign s1_load  = !s1_valid_reg || out_load;
    assign raw.ready = s1_load;

    assign w_type      = s1_word_reg[31:27];
    assign w_chan      = s1_word_reg[25:21];
    assign w_trailing  = s1_word_reg[26];
    assign in_range    = {1'b0, w_chan} < (CHAN_W + 1)'(CHANNELS);
    assign ch_idx      = IDX_W'(w_chan);
    assign cnt_cur     = !in_range ? '0 : (w_trailing ? trail_reg[ch_idx] : lead_reg[ch_idx]);
    assign good_header = (w_type == TYPE_EVENT_HEADER);
    assign hit_keep    = in_range && (cnt_cur < HIT_CNT_W'(HITS_PER_EDGE));

    always_comb
    begin
        out_next        = '0;
        out_next.word_class = CLS_IGNORED;
        event_open_next = event_open_reg;
        geo_next        = geo_reg;
        if (s1_first_reg)
        begin
            if (good_header)
            begin
                out_next.word_class  = CLS_HEADER;
                out_next.value       = VALUE_W'(s1_word_reg[5 +: TRIG_W]);
                out_next.geo_address = s1_word_reg[GEO_W-1:0];
                geo_next             = s1_word_reg[GEO_W-1:0];
                event_open_next      = 1'b1;
            end
            else
            begin
                out_next.word_class = CLS_BAD_HEADER;
                geo_next            = '0;
                event_open_next     = 1'b0;
            end
        end
        else if (event_open_reg)
        begin
            out_next.geo_address = geo_reg;
            case (w_type)
                TYPE_MEASUREMENT:
                begin
                    out_next.channel  = w_chan;
                    out_next.edge_res = w_trailing;
                    out_next.value    = VALUE_W'(s1_word_reg[TIME_W-1:0]);
                    if (hit_keep)
                    begin
                        out_next.word_class = CLS_HIT_KEPT;
                        out_next.hit_slot   = cnt_cur;
                    end
                    else
                    begin
                        out_next.word_class = CLS_HIT_DROP;
                        out_next.hit_slot   = SLOT_DROPPED;
                    end
                end
                TYPE_TDC_HEADER:
                begin
                    out_next.word_class     = CLS_TDC_HEADER;
                    out_next.tdc_channel_id = s1_word_reg[23:12];
                    out_next.tdc_packet_id  = s1_word_reg[11:0];
                end
                TYPE_TRAILER:
                begin
                    out_next.word_class = CLS_TRAILER;
                    out_next.value      = s1_word_reg[VALUE_W-1:0];
                end
                TYPE_TAG_LOW:
                begin
                    out_next.word_class = CLS_TAG_LOW;
                    out_next.value      = VALUE_W'(s1_word_reg[4:0]);
                end
                TYPE_TAG_HIGH:
                begin
                    out_next.word_class = CLS_TAG_HIGH;
                    out_next.value      = s1_word_reg[VALUE_W-1:0];
                end
                default:
                begin
                    out_next.word_class = CLS_UNKNOWN;
                    out_next.value      = s1_word_reg[VALUE_W-1:0];
                end
            endcase
        end
        if (s1_last_reg)
        begin
            event_open_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            event_open_reg <= 1'b0;
            geo_reg        <= '0;
            for (int i = 0; i < int'(CHANNELS); i++)
            begin
                lead_reg[i]  <= '0;
                trail_reg[i] <= '0;
            end
        end
        else
        begin
            if (s1_load)
            begin
                s1_valid_reg <= raw.valid;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (decoded.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (out_load)
            begin
                event_open_reg <= event_open_next;
                geo_reg        <= geo_next;
                if (s1_first_reg)
                begin
                    for (int i = 0; i < int'(CHANNELS); i++)
                    begin
                        lead_reg[i]  <= '0;
                        trail_reg[i] <= '0;
                    end
                end
                else if (event_open_reg && (w_type == TYPE_MEASUREMENT) && hit_keep)
                begin
                    if (w_trailing)
                    begin
                        trail_reg[ch_idx] <= cnt_cur + HIT_CNT_W'(1);
                    end
                    else
                    begin
                        lead_reg[ch_idx] <= cnt_cur + HIT_CNT_W'(1);
                    end
                end
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (s1_load && raw.valid)
        begin
            s1_word_reg  <= raw.word;
            s1_first_reg <= raw.first_of_event;
            s1_last_reg  <= raw.last_of_event;
        end
        if (out_load)
        begin
            out_reg <= out_next;
        end
    end

    assign decoded.valid          = out_valid_reg;
    assign decoded.word_class     = out_reg.word_class;
    assign decoded.channel        = out_reg.channel;
    assign decoded.edge_res       = out_reg.edge_res;
    assign decoded.hit_slot       = out_reg.hit_slot;
    assign decoded.value          = out_reg.value;
    assign decoded.geo_address    = out_reg.geo_address;
    assign decoded.tdc_channel_id = out_reg.tdc_channel_id;
    assign decoded.tdc_packet_id  = out_reg.tdc_packet_id;

`ifndef ASSERT_OFF
    kept_slot_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        decoded.valid && (decoded.word_class == CLS_HIT_KEPT)
        |-> (decoded.hit_slot < SLOT_W'(HITS_PER_EDGE)))
        else $error("kept hit with slot beyond hit limit");

    dropped_slot_marked: assert property (@(posedge clk) disable iff (!rst_n)
        decoded.valid && (decoded.word_class == CLS_HIT_DROP)
        |-> (decoded.hit_slot == SLOT_DROPPED))
        else $error("dropped hit without dropped slot");

    ignored_word_clean: assert property (@(posedge clk) disable iff (!rst_n)
        decoded.valid && ((decoded.word_class == CLS_IGNORED)
                          || (decoded.word_class == CLS_BAD_HEADER))
        |-> (decoded.geo_address == '0) && (decoded.value == '0))
        else $error("ignored or bad header word carries data");

    bad_header_closes: assert property (@(posedge clk) disable iff (!rst_n)
        out_load && s1_first_reg && !good_header |=> !event_open_reg)
        else $error("event left open after bad header");

    header_clears_counters: assert property (@(posedge clk) disable iff (!rst_n)
        out_load && s1_first_reg |=> (lead_reg[0] == '0) && (trail_reg[0] == '0))
        else $error("hit counters not cleared by header");
`endif

endmodule

`default_nettype wire

// ===== verif/tdc_event_word_decoder_core_test.sv =====
`timescale 1ns / 1ps

module tdc_event_word_decoder_core_test;
    import tdcewd_pkg::*;

    localparam int unsigned NUM_CHANNELS = 16;
    localparam int unsigned HITS_KEPT    = 3;
    localparam int unsigned WORDS_PER_PHASE = 400;

    typedef struct {
        logic [WORD_W-1:0] word;
        logic              first;
        logic              last;
        logic              typed;
        result_t           result;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n;

    tdcewd_in_if  raw ();
    tdcewd_out_if decoded ();

    tdc_event_word_decoder_core #(
        .CHANNELS      (NUM_CHANNELS),
        .HITS_PER_EDGE (HITS_KEPT)
    ) DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .raw     (raw),
        .decoded (decoded)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // decoder state as the words are accepted
    logic [HIT_CNT_W-1:0] lead_seen [NUM_CHANNELS];
    logic [HIT_CNT_W-1:0] trail_seen [NUM_CHANNELS];
    logic                 evt_open;
    logic [GEO_W-1:0]     evt_geo;

    result_t   pending_decodes [$];
    stim_row_t directed_rows [$];
    result_t   got_word;
    result_t   want_word;
    int        errors = 0;
    int        sent_words = 0;
    int        send_idle_pct = 0;
    int        recv_stall_pct = 0;

    function automatic result_t decoded_word(input logic [CLASS_W-1:0] cls,
                                             input logic [CHAN_W-1:0] ch,
                                             input logic edge_bit,
                                             input logic [SLOT_W-1:0] slot,
                                             input logic [VALUE_W-1:0] val,
                                             input logic [GEO_W-1:0] geo,
                                             input logic [ID_W-1:0] cid,
                                             input logic [ID_W-1:0] pid);
        result_t r;
        r.word_class     = cls;
        r.channel        = ch;
        r.edge_res       = edge_bit;
        r.hit_slot       = slot;
        r.value          = val;
        r.geo_address    = geo;
        r.tdc_channel_id = cid;
        r.tdc_packet_id  = pid;
        return r;
    endfunction

    function automatic result_t decode_readout(input logic [WORD_W-1:0] w, input logic first,
                                               input logic last);
        result_t             r;
        logic [TYPE_W-1:0]   wtype;
        logic [VALUE_W-1:0]  body;
        logic [CHAN_W-1:0]   ch;
        logic                trailing;
        r = '0;
        r.word_class = CLS_IGNORED;
        wtype = w[31:27];
        body = w[26:0];
        if (first)
        begin
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                lead_seen[i] = '0;
                trail_seen[i] = '0;
            end
            if (wtype == TYPE_EVENT_HEADER)
            begin
                evt_geo = w[4:0];
                evt_open = 1'b1;
                r.word_class = CLS_HEADER;
                r.value = VALUE_W'(w[26:5]);
                r.geo_address = evt_geo;
            end
            else
            begin
                evt_geo = '0;
                evt_open = 1'b0;
                r.word_class = CLS_BAD_HEADER;
            end
        end
        else if (evt_open)
        begin
            r.geo_address = evt_geo;
            case (wtype)
                TYPE_MEASUREMENT:
                begin
                    ch = body[25:21];
                    trailing = body[26];
                    r.channel = ch;
                    r.edge_res = trailing;
                    r.value = VALUE_W'(body[19:0]);
                    r.word_class = CLS_HIT_DROP;
                    r.hit_slot = SLOT_DROPPED;
                    if (ch < NUM_CHANNELS)
                    begin
                        if (trailing && trail_seen[ch[3:0]] < HITS_KEPT)
                        begin
                            r.hit_slot = trail_seen[ch[3:0]];
                            trail_seen[ch[3:0]] = trail_seen[ch[3:0]] + HIT_CNT_W'(1);
                            r.word_class = CLS_HIT_KEPT;
                        end
                        else if (!trailing && lead_seen[ch[3:0]] < HITS_KEPT)
                        begin
                            r.hit_slot = lead_seen[ch[3:0]];
                            lead_seen[ch[3:0]] = lead_seen[ch[3:0]] + HIT_CNT_W'(1);
                            r.word_class = CLS_HIT_KEPT;
                        end
                    end
                end
                TYPE_TDC_HEADER:
                begin
                    r.word_class = CLS_TDC_HEADER;
                    r.tdc_channel_id = body[23:12];
                    r.tdc_packet_id = body[11:0];
                end
                TYPE_TRAILER:
                begin
                    r.word_class = CLS_TRAILER;
                    r.value = body;
                end
                TYPE_TAG_LOW:
                begin
                    r.word_class = CLS_TAG_LOW;
                    r.value = VALUE_W'(body[4:0]);
                end
                TYPE_TAG_HIGH:
                begin
                    r.word_class = CLS_TAG_HIGH;
                    r.value = body;
                end
                default:
                begin
                    r.word_class = CLS_UNKNOWN;
                    r.value = body;
                end
            endcase
        end
        if (last)
            evt_open = 1'b0;
        return r;
    endfunction

    task automatic add_row(input logic [WORD_W-1:0] w, input logic first, input logic last,
                           input logic typed, input result_t r);
        stim_row_t row;
        row.word = w;
        row.first = first;
        row.last = last;
        row.typed = typed;
        row.result = r;
        directed_rows.push_back(row);
    endtask

    task automatic put_word(input logic [WORD_W-1:0] w, input logic first, input logic last,
                            input logic typed, input result_t typed_result);
        result_t predicted;
        while ($urandom_range(99) < send_idle_pct)
        begin
            raw.valid <= 1'b0;
            @(posedge clk);
        end
        raw.valid <= 1'b1;
        raw.word <= w;
        raw.first_of_event <= first;
        raw.last_of_event <= last;
        @(posedge clk);
        while (!raw.ready)
            @(posedge clk);
        predicted = decode_readout(w, first, last);
        pending_decodes.push_back(typed ? typed_result : predicted);
        sent_words++;
    endtask

    task automatic wait_drained();
        raw.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_decodes.size() != 0);
    endtask

    function automatic logic [WORD_W-1:0] random_body_word();
        logic [WORD_W-1:0] w;
        int                pick;
        int                sel;
        w = $urandom;
        pick = $urandom_range(99);
        if (pick < 50)
        begin
            w[31:27] = TYPE_MEASUREMENT;
            sel = $urandom_range(9);
            // crowd a few channels so the hit counters saturate
            if (sel < 7)
                w[25:21] = CHAN_W'($urandom_range(3));
            else if (sel < 9)
                w[25:21] = CHAN_W'($urandom_range(15));
            else
                w[25:21] = CHAN_W'($urandom_range(31, 16));
        end
        else if (pick < 60)
            w[31:27] = TYPE_TDC_HEADER;
        else if (pick < 68)
            w[31:27] = TYPE_TRAILER;
        else if (pick < 76)
            w[31:27] = TYPE_TAG_LOW;
        else if (pick < 84)
            w[31:27] = TYPE_TAG_HIGH;
        return w;
    endfunction

    task automatic run_event();
        logic [WORD_W-1:0] hdr;
        int                n;
        logic              last;
        n = $urandom_range(24);
        hdr = $urandom;
        if ($urandom_range(9) == 0)
        begin
            if (hdr[31:27] == TYPE_EVENT_HEADER)
                hdr[31] = 1'b1;
        end
        else
            hdr[31:27] = TYPE_EVENT_HEADER;
        last = (n == 0) ? 1'($urandom_range(1)) : ($urandom_range(19) == 0);
        put_word(hdr, 1'b1, last, 1'b0, '0);
        for (int i = 0; i < n; i++)
        begin
            last = (i == n - 1) ? ($urandom_range(9) != 0) : ($urandom_range(49) == 0);
            put_word(random_body_word(), 1'b0, last, 1'b0, '0);
        end
        // stray words between events
        if ($urandom_range(9) == 0)
            repeat ($urandom_range(3, 1))
                put_word($urandom, $urandom_range(7) == 0, 1'($urandom_range(1)), 1'b0, '0);
    endtask

    task automatic check_field(input string name, input logic [31:0] want_v,
                               input logic [31:0] got_v);
        if (want_v !== got_v)
        begin
            errors++;
            $display("%0t: %s expected %h got %h", $time, name, want_v, got_v);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && decoded.valid && decoded.ready)
        begin
            got_word.word_class = decoded.word_class;
            got_word.channel = decoded.channel;
            got_word.edge_res = decoded.edge_res;
            got_word.hit_slot = decoded.hit_slot;
            got_word.value = decoded.value;
            got_word.geo_address = decoded.geo_address;
            got_word.tdc_channel_id = decoded.tdc_channel_id;
            got_word.tdc_packet_id = decoded.tdc_packet_id;
            if (pending_decodes.size() == 0)
            begin
                errors++;
                $display("%0t: decoded word with nothing pending, expected none got class %h",
                         $time, got_word.word_class);
            end
            else
            begin
                want_word = pending_decodes.pop_front();
                check_field("word_class", 32'(want_word.word_class),
                            32'(got_word.word_class));
                check_field("channel", 32'(want_word.channel), 32'(got_word.channel));
                check_field("edge_res", 32'(want_word.edge_res), 32'(got_word.edge_res));
                check_field("hit_slot", 32'(want_word.hit_slot), 32'(got_word.hit_slot));
                check_field("value", 32'(want_word.value), 32'(got_word.value));
                check_field("geo_address", 32'(want_word.geo_address),
                            32'(got_word.geo_address));
                check_field("tdc_channel_id", 32'(want_word.tdc_channel_id),
                            32'(got_word.tdc_channel_id));
                check_field("tdc_packet_id", 32'(want_word.tdc_packet_id),
                            32'(got_word.tdc_packet_id));
            end
        end
        decoded.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    initial
    begin
        rst_n <= 1'b0;
        raw.valid <= 1'b0;
        raw.word <= '0;
        raw.first_of_event <= 1'b0;
        raw.last_of_event <= 1'b0;
        evt_open = 1'b0;
        evt_geo = '0;
        for (int i = 0; i < NUM_CHANNELS; i++)
        begin
            lead_seen[i] = '0;
            trail_seen[i] = '0;
        end

        // nothing open yet, then a bad header closes everything
        add_row(32'h0000_0000, 1'b0, 1'b0, 1'b1, decoded_word(CLS_IGNORED, 0, 0, 0, 0, 0, 0, 0));
        add_row(32'hFFFF_FFFF, 1'b1, 1'b0, 1'b1,
                decoded_word(CLS_BAD_HEADER, 0, 0, 0, 0, 0, 0, 0));
        add_row(32'h0000_0000, 1'b0, 1'b0, 1'b1, decoded_word(CLS_IGNORED, 0, 0, 0, 0, 0, 0, 0));
        add_row(32'h47FF_FFFF, 1'b1, 1'b0, 1'b1,
                decoded_word(CLS_HEADER, 0, 0, 0, 27'h3F_FFFF, 5'd31, 0, 0));
        add_row(32'h000F_FFFF, 1'b0, 1'b0, 1'b1,
                decoded_word(CLS_HIT_KEPT, 0, 0, 0, 27'hF_FFFF, 5'd31, 0, 0));
        add_row(32'h0000_0000, 1'b0, 1'b0, 1'b0, '0);
        add_row(32'h0010_0001, 1'b0, 1'b0, 1'b0, '0);
        // fourth leading hit on channel 0 saturates
        add_row(32'h0000_0005, 1'b0, 1'b0, 1'b0, '0);
        add_row(32'h05E1_2345, 1'b0, 1'b0, 1'b0, '0);
        add_row(32'h07FF_FFFF, 1'b0, 1'b0, 1'b1,
                decoded_word(CLS_HIT_DROP, 5'd31, 1'b1, SLOT_DROPPED, 27'hF_FFFF, 5'd31, 0, 0));
        add_row(32'h0FFF_FFFF, 1'b0, 1'b0, 1'b1,
                decoded_word(CLS_TDC_HEADER, 0, 0, 0, 0, 5'd31, 12'hFFF, 12'hFFF));
        add_row(32'h1FFF_FFFF, 1'b0, 1'b0, 1'b1,
                decoded_word(CLS_TRAILER, 0, 0, 0, 27'h7FF_FFFF, 5'd31, 0, 0));
        add_row(32'h87FF_FFFF, 1'b0, 1'b0, 1'b1,
                decoded_word(CLS_TAG_LOW, 0, 0, 0, 27'h1F, 5'd31, 0, 0));
        add_row(32'h8812_3456, 1'b0, 1'b0, 1'b0, '0);
        add_row(32'hF800_0000, 1'b0, 1'b0, 1'b1,
                decoded_word(CLS_UNKNOWN, 0, 0, 0, 0, 5'd31, 0, 0));
        // header type without the first flag is just an unknown word
        add_row(32'h4000_0000, 1'b0, 1'b0, 1'b0, '0);
        add_row(32'h0020_0000, 1'b0, 1'b1, 1'b0, '0);
        add_row(32'h0000_0000, 1'b0, 1'b0, 1'b1, decoded_word(CLS_IGNORED, 0, 0, 0, 0, 0, 0, 0));
        add_row(32'h4000_0020, 1'b1, 1'b1, 1'b1,
                decoded_word(CLS_HEADER, 0, 0, 0, 27'd1, 5'd0, 0, 0));
        add_row(32'hFFFF_FFFF, 1'b0, 1'b0, 1'b1, decoded_word(CLS_IGNORED, 0, 0, 0, 0, 0, 0, 0));
        add_row(32'h4000_0001, 1'b1, 1'b0, 1'b0, '0);
        add_row(32'h0000_0000, 1'b0, 1'b0, 1'b0, '0);
        add_row(32'h4800_0000, 1'b1, 1'b0, 1'b1,
                decoded_word(CLS_BAD_HEADER, 0, 0, 0, 0, 0, 0, 0));
        add_row(32'h0000_0000, 1'b0, 1'b0, 1'b1, decoded_word(CLS_IGNORED, 0, 0, 0, 0, 0, 0, 0));
        add_row(32'h0000_0000, 1'b1, 1'b1, 1'b1,
                decoded_word(CLS_BAD_HEADER, 0, 0, 0, 0, 0, 0, 0));

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            put_word(directed_rows[i].word, directed_rows[i].first, directed_rows[i].last,
                     directed_rows[i].typed, directed_rows[i].result);
        wait_drained();

        for (int phase = 0; phase < 4; phase++)
        begin
            int start_words;
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 82; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 82; end
                default: begin send_idle_pct = 36; recv_stall_pct = 36; end
            endcase
            start_words = sent_words;
            while (sent_words - start_words < WORDS_PER_PHASE)
                run_event();
            wait_drained();
        end

        recv_stall_pct = 0;
        repeat (8) @(posedge clk);
        if (errors == 0)
            $display("tdc_event_word_decoder_core: match");
        else
            $display("tdc_event_word_decoder_core: mismatch");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("tdc_event_word_decoder_core: mismatch");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/tdcewd_pkg.sv
hw/rtl/tdcewd_if.sv
hw/rtl/tdc_event_word_decoder_core.sv
verif/tdc_event_word_decoder_core_test.sv
